// ----- src/call_stack_exclusive_time_core_assert.svh -----
// Assertion macros for the checker file of the call stack profiler.
// Needs a clk and an arst_n in the scope where a macro is used.
`ifndef CALL_STACK_EXCLUSIVE_TIME_CORE_ASSERT_SVH
`define CALL_STACK_EXCLUSIVE_TIME_CORE_ASSERT_SVH

// Checked only outside reset.
`define CSET_CHK(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("cset check failed");

// Checked during reset too.
`define CSET_CHK_RST(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("cset reset check failed");

`endif

// ----- src/cset_pkg.sv -----
// Package of the call stack profiler: sizes, codes, item and control types.
// No dependencies.
package cset_pkg;

	localparam int NUM_FUNCS   = 256;
	localparam int STACK_DEPTH = 64;

	localparam int FUNC_W  = 8;
	localparam int TIME_W  = 32;
	localparam int SIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int FADDR_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_END   = 1'b1;

	localparam logic [1:0] STAT_PUSHED  = 2'd0;
	localparam logic [1:0] STAT_MATCHED = 2'd1;
	localparam logic [1:0] STAT_IGNORED = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_DUR  = 2'd0;
	localparam alu_op_t ALU_SUBF = 2'd1;
	localparam alu_op_t ALU_ADDS = 2'd2;

	typedef struct packed {
		logic              command;
		logic [FUNC_W-1:0] func_id;
		logic [TIME_W-1:0] timestamp;
	} evt_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [FUNC_W-1:0] result_func;
		logic [TIME_W-1:0] call_exclusive;
		logic [TIME_W-1:0] func_total;
	} res_item_t;

	typedef struct packed {
		alu_op_t           op;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] child;
	} stk_word_t;

endpackage

// ----- src/call_stack_exclusive_time_core.sv -----
// Call stack exclusive time profiler: sequencer, stack and totals memories.
// Depends on cset_pkg, cset_ram, cset_alu.
//
//   channel | handshake            | payload
//   evt     | evt_valid, evt_stall | evt (command, func_id, timestamp)
//   res     | res_valid, res_stall | res (status, result_func, call_exclusive, func_total)
//
// One item at a time; evt_stall is high from acceptance until the result is
// loaded into the output register. A matched end reads the stack top and, if
// there is one, its parent through the single stack RAM read port, and makes
// four passes through the shared arithmetic unit. A held result delays the load
// of the next one, and so the acceptance of the event after it. Reset clears
// the stack count and the valid bits of the totals table at once; no clearing pass.
module call_stack_exclusive_time_core
	import cset_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_stall,
	input  evt_item_t evt,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TOP  = 3'd1;
	localparam logic [2:0] S_EXCL = 3'd2;
	localparam logic [2:0] S_TOT  = 3'd3;
	localparam logic [2:0] S_PAR  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_FUNCS-1:0] tot_vld_q;
	logic                 res_valid_q;
	res_item_t            res_q;

	logic [FUNC_W-1:0] id_q;
	logic [TIME_W-1:0] ts_q;
	logic [TIME_W-1:0] child_q;
	logic [TIME_W-1:0] dur_q;
	logic [TIME_W-1:0] excl_q;
	logic [TIME_W-1:0] tot_q;
	logic [1:0]        status_q;
	logic              tot_rd_vld_q;

	logic              evt_acc;
	logic              full;
	logic              empty;
	logic              has_par;
	logic              match;
	logic              tot_ok;
	logic [CNT_W-1:0]  cnt_dec;
	logic [CNT_W-1:0]  cnt_dec2;
	logic [SIDX_W-1:0] top_idx;
	logic [SIDX_W-1:0] par_idx;
	logic [FADDR_W-1:0] faddr;
	logic              res_load;

	logic              stk_we;
	logic [SIDX_W-1:0] stk_waddr;
	stk_word_t         stk_wdata;
	logic              stk_re;
	logic [SIDX_W-1:0] stk_raddr;
	stk_word_t         stk_rdata;

	logic              tot_we;
	logic              tot_re;
	logic [TIME_W-1:0] tot_rdata;

	alu_req_t          alu_req;
	logic [TIME_W-1:0] alu_y;

	assign evt_acc  = evt_valid && (state_q == S_IDLE);
	assign full     = (cnt_q == CNT_W'(STACK_DEPTH));
	assign empty    = (cnt_q == '0);
	assign has_par  = (cnt_q >= CNT_W'(2));
	assign cnt_dec  = cnt_q - CNT_W'(1);
	assign cnt_dec2 = cnt_q - CNT_W'(2);
	assign top_idx  = cnt_dec[SIDX_W-1:0];
	assign par_idx  = cnt_dec2[SIDX_W-1:0];
	assign match    = (stk_rdata.func == id_q);
	assign tot_ok   = (32'(id_q) < 32'(NUM_FUNCS));
	assign faddr    = FADDR_W'(id_q);
	assign res_load = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = cnt_q[SIDX_W-1:0];
		stk_wdata = '{func: evt.func_id, start: evt.timestamp, child: '0};
		if (evt_acc && (evt.command == CMD_START) && !full) begin
			stk_we = 1'b1;
		end else if ((state_q == S_PAR) && has_par) begin
			stk_we    = 1'b1;
			stk_waddr = par_idx;
			stk_wdata = '{func: stk_rdata.func, start: stk_rdata.start, child: alu_y};
		end
	end

	assign stk_re = (evt_acc && (evt.command == CMD_END) && !empty)
		|| ((state_q == S_TOP) && match && has_par);
	assign stk_raddr = (state_q == S_IDLE) ? top_idx : par_idx;

	assign tot_re = (state_q == S_TOP) && match && tot_ok;
	assign tot_we = (state_q == S_TOT) && tot_ok;

	always_comb begin
		alu_req = '{op: ALU_DUR, a: ts_q, b: stk_rdata.start};
		case (state_q)
			S_EXCL:  alu_req = '{op: ALU_SUBF, a: dur_q, b: child_q};
			S_TOT:   alu_req = '{op: ALU_ADDS, a: tot_rd_vld_q ? tot_rdata : '0, b: excl_q};
			S_PAR:   alu_req = '{op: ALU_ADDS, a: stk_rdata.child, b: dur_q};
			default: alu_req = '{op: ALU_DUR, a: ts_q, b: stk_rdata.start};
		endcase
	end

	cset_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	cset_ram #(
		.WIDTH ($bits(stk_word_t)),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	cset_ram #(
		.WIDTH (TIME_W),
		.DEPTH (NUM_FUNCS)
	) u_totals_ram (
		.clk   (clk),
		.we    (tot_we),
		.waddr (faddr),
		.wdata (alu_y),
		.re    (tot_re),
		.raddr (faddr),
		.rdata (tot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			tot_vld_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (tot_we) begin
				tot_vld_q[faddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (evt_acc) begin
						if (evt.command == CMD_START) begin
							if (!full) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
							state_q <= S_DONE;
						end else begin
							state_q <= empty ? S_DONE : S_TOP;
						end
					end
				end
				S_TOP:  state_q <= match ? S_EXCL : S_DONE;
				S_EXCL: state_q <= S_TOT;
				S_TOT:  state_q <= S_PAR;
				S_PAR: begin
					cnt_q   <= cnt_dec;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			id_q   <= evt.func_id;
			ts_q   <= evt.timestamp;
			excl_q <= '0;
			tot_q  <= '0;
			if (evt.command == CMD_START) begin
				status_q <= full ? STAT_FULL : STAT_PUSHED;
			end else begin
				status_q <= STAT_IGNORED;
			end
		end
		if (state_q == S_TOP) begin
			child_q      <= stk_rdata.child;
			dur_q        <= alu_y;
			tot_rd_vld_q <= tot_vld_q[faddr];
		end
		if (state_q == S_EXCL) begin
			excl_q <= alu_y;
		end
		if (state_q == S_TOT) begin
			tot_q <= tot_ok ? alu_y : '0;
		end
		if (state_q == S_PAR) begin
			status_q <= STAT_MATCHED;
		end
		if (res_load) begin
			res_q <= '{status: status_q, result_func: id_q,
				call_exclusive: excl_q, func_total: tot_q};
		end
	end

	assign evt_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- src/cset_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cset_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/cset_alu.sv -----
// Shared saturating arithmetic unit: duration, floored subtract, saturating add.
// Depends on cset_pkg.
module cset_alu
	import cset_pkg::*;
(
	input  alu_req_t          req,
	output logic [TIME_W-1:0] y
);

	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] diff;

	assign sum  = {1'b0, req.a} + {1'b0, req.b};
	assign diff = req.a - req.b;

	always_comb begin
		unique case (req.op)
			ALU_DUR: begin
				if (req.a < req.b) begin
					y = '0;
				end else if (diff == TIME_MAX) begin
					y = TIME_MAX;
				end else begin
					y = diff + TIME_W'(1);
				end
			end
			ALU_SUBF: begin
				y = (req.a > req.b) ? diff : '0;
			end
			ALU_ADDS: begin
				y = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
			end
			default: begin
				y = '0;
			end
		endcase
	end

endmodule

// ----- src/cset_checker.sv -----
// Port level checks of the call stack profiler, bound to the top level.
// Depends on cset_pkg and call_stack_exclusive_time_core_assert.svh.
`include "call_stack_exclusive_time_core_assert.svh"

module cset_checker
	import cset_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      evt_valid,
	input logic      evt_stall,
	input evt_item_t evt,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res
);

	`CSET_CHK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res))
	`CSET_CHK(a_busy_after_accept, evt_valid && !evt_stall |=> evt_stall)
	`CSET_CHK(a_zero_unless_match, res_valid && (res.status != STAT_MATCHED) |-> (res.call_exclusive == '0) && (res.func_total == '0))
	`CSET_CHK(a_total_covers_call, res_valid && (res.status == STAT_MATCHED) && (32'(res.result_func) < 32'(NUM_FUNCS)) |-> res.func_total >= res.call_exclusive)
	`CSET_CHK_RST(a_reset_quiet, !arst_n |-> !res_valid && !evt_stall)

endmodule

bind call_stack_exclusive_time_core cset_checker u_cset_checker (.*);

// ----- bench/call_stack_exclusive_time_core_tb.sv -----
// Self-checking bench for call_stack_exclusive_time_core: directed table, then random trace
// events checked against a shadow call stack and a shadow totals table.
// Depends on cset_pkg and the core RTL.
module call_stack_exclusive_time_core_tb;
	import cset_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_EVENTS = 1100;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		evt_item_t ev;
		logic      fixed_exp;
		res_item_t want;
	} vec_row_t;

	logic      clk;
	logic      arst_n;
	logic      evt_valid;
	logic      evt_stall;
	evt_item_t evt;
	logic      res_valid;
	logic      res_stall;
	res_item_t res;

	logic [FUNC_W-1:0] shadow_func [STACK_DEPTH];
	logic [TIME_W-1:0] shadow_start [STACK_DEPTH];
	logic [TIME_W-1:0] shadow_child [STACK_DEPTH];
	logic [TIME_W-1:0] func_totals [NUM_FUNCS] = '{default: '0};
	int                shadow_depth = 0;

	res_item_t pending_results [$];
	int        fail_count = 0;
	int        counted = 0;
	int        cycle_count = 0;
	bit        send_burst = 1'b0;
	bit        recv_burst = 1'b0;

	// typed expectations: empty/mismatched end, saturation, floor, time backwards
	vec_row_t directed_rows [24] = '{
		'{'{CMD_END,   8'h00, 32'h0000_0000}, 1'b1, '{STAT_IGNORED, 8'h00, 32'h0, 32'h0}},
		'{'{CMD_START, 8'hFF, 32'h0000_0000}, 1'b1, '{STAT_PUSHED,  8'hFF, 32'h0, 32'h0}},
		'{'{CMD_END,   8'h00, 32'h0000_0005}, 1'b1, '{STAT_IGNORED, 8'h00, 32'h0, 32'h0}},
		'{'{CMD_START, 8'h00, 32'h0000_000A}, 1'b1, '{STAT_PUSHED,  8'h00, 32'h0, 32'h0}},
		'{'{CMD_END,   8'h00, 32'h0000_0009}, 1'b1, '{STAT_MATCHED, 8'h00, 32'h0, 32'h0}},
		'{'{CMD_START, 8'h01, 32'h0000_0000}, 1'b1, '{STAT_PUSHED,  8'h01, 32'h0, 32'h0}},
		'{'{CMD_END,   8'h01, 32'hFFFF_FFFF}, 1'b1,
			'{STAT_MATCHED, 8'h01, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
		'{'{CMD_START, 8'h02, 32'h0000_0000}, 1'b1, '{STAT_PUSHED,  8'h02, 32'h0, 32'h0}},
		'{'{CMD_END,   8'h02, 32'hFFFF_FFFF}, 1'b1,
			'{STAT_MATCHED, 8'h02, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
		'{'{CMD_END,   8'hFF, 32'hFFFF_FFFF}, 1'b1, '{STAT_MATCHED, 8'hFF, 32'h0, 32'h0}},
		'{'{CMD_START, 8'h01, 32'h0000_0000}, 1'b1, '{STAT_PUSHED,  8'h01, 32'h0, 32'h0}},
		'{'{CMD_END,   8'h01, 32'h0000_0003}, 1'b1,
			'{STAT_MATCHED, 8'h01, 32'h4, 32'hFFFF_FFFF}},
		'{'{CMD_END,   8'h01, 32'h0000_0004}, 1'b1, '{STAT_IGNORED, 8'h01, 32'h0, 32'h0}},
		'{'{CMD_START, 8'h10, 32'd100},       1'b0, '0},
		'{'{CMD_START, 8'h11, 32'd100},       1'b0, '0},
		'{'{CMD_END,   8'h11, 32'd200},       1'b0, '0},
		'{'{CMD_END,   8'h10, 32'd150},       1'b0, '0},
		'{'{CMD_START, 8'hAA, 32'h5555_5555}, 1'b0, '0},
		'{'{CMD_START, 8'h55, 32'hAAAA_AAAA}, 1'b0, '0},
		'{'{CMD_END,   8'hAA, 32'hAAAA_AAAB}, 1'b1, '{STAT_IGNORED, 8'hAA, 32'h0, 32'h0}},
		'{'{CMD_END,   8'h55, 32'hFFFF_FFFE}, 1'b0, '0},
		'{'{CMD_END,   8'hAA, 32'hFFFF_FFFF}, 1'b0, '0},
		'{'{CMD_START, 8'h80, 32'h0000_0001}, 1'b0, '0},
		'{'{CMD_END,   8'h80, 32'h0000_0001}, 1'b0, '0}
	};

	call_stack_exclusive_time_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** call_stack_exclusive_time_core: FAILED **");
			$finish;
		end
	end

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

	// applies one trace event to the shadow stack and totals, returns the result item
	function automatic res_item_t trace_step(input evt_item_t e);
		res_item_t         r;
		logic [TIME_W:0]   span;
		logic [TIME_W-1:0] dur;
		int                top;
		r = '0;
		r.result_func = e.func_id;
		if (e.command == CMD_START) begin
			if (shadow_depth >= STACK_DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				shadow_func[shadow_depth] = e.func_id;
				shadow_start[shadow_depth] = e.timestamp;
				shadow_child[shadow_depth] = '0;
				shadow_depth++;
				r.status = STAT_PUSHED;
			end
		end else if (shadow_depth == 0 || shadow_func[shadow_depth-1] != e.func_id) begin
			r.status = STAT_IGNORED;
		end else begin
			top = shadow_depth - 1;
			if (e.timestamp < shadow_start[top]) begin
				dur = '0;
			end else begin
				span = {1'b0, e.timestamp} - {1'b0, shadow_start[top]} + 1'b1;
				dur = span[TIME_W] ? TIME_MAX : span[TIME_W-1:0];
			end
			r.call_exclusive = (dur > shadow_child[top]) ? dur - shadow_child[top] : '0;
			if (int'(e.func_id) < NUM_FUNCS) begin
				func_totals[e.func_id] = sat_add(func_totals[e.func_id], r.call_exclusive);
				r.func_total = func_totals[e.func_id];
			end
			shadow_depth = top;
			if (top > 0)
				shadow_child[top-1] = sat_add(shadow_child[top-1], dur);
			r.status = STAT_MATCHED;
		end
		return r;
	endfunction

	task automatic feed_event(input evt_item_t e, input logic fixed_exp, input res_item_t want);
		int        gap;
		res_item_t got;
		if ($urandom_range(0, 39) == 0)
			send_burst = ~send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		evt <= e;
		do @(posedge clk); while (evt_stall);
		got = trace_step(e);
		pending_results.push_back(fixed_exp ? want : got);
		if (got.status != STAT_IGNORED)
			counted++;
	endtask

	task automatic check_result(input res_item_t got);
		res_item_t exp;
		if (pending_results.size() == 0) begin
			$error("result item with nothing pending: status %0d func %0h", got.status,
				got.result_func);
			fail_count++;
		end else begin
			exp = pending_results.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				fail_count++;
			end
			if (got.result_func !== exp.result_func) begin
				$error("result_func: expected %0h, got %0h", exp.result_func, got.result_func);
				fail_count++;
			end
			if (got.call_exclusive !== exp.call_exclusive) begin
				$error("call_exclusive: expected %0h, got %0h", exp.call_exclusive,
					got.call_exclusive);
				fail_count++;
			end
			if (got.func_total !== exp.func_total) begin
				$error("func_total: expected %0h, got %0h", exp.func_total, got.func_total);
				fail_count++;
			end
		end
	endtask

	// result side: random hold-off per item, then take it
	initial begin
		int hold;
		res_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_burst = ~recv_burst;
			hold = recv_burst ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
			check_result(res);
		end
	end

	initial begin
		evt_item_t         e;
		res_item_t         none;
		int                pick;
		int                n;
		int                top;
		logic [TIME_W-1:0] now;
		// nonblocking, so the reset edge lands after every process has started
		arst_n <= 1'b0;
		evt_valid = 1'b0;
		evt = '0;
		none = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			feed_event(directed_rows[i].ev, directed_rows[i].fixed_exp, directed_rows[i].want);

		now = $urandom_range(0, 1000);
		while (counted < RAND_EVENTS) begin
			pick = $urandom_range(0, 199);
			if (pick == 0) begin
				// fill to the top and push past it
				n = STACK_DEPTH - shadow_depth + $urandom_range(1, 3);
				repeat (n) begin
					now += $urandom_range(0, 3);
					e = '{CMD_START, 8'($urandom_range(0, 255)), now};
					feed_event(e, 1'b0, none);
				end
			end else if (pick < 14) begin
				e = '{1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 32'($urandom)};
				feed_event(e, 1'b0, none);
			end else if (pick < 26 && shadow_depth > 0) begin
				top = shadow_depth - 1;
				e = '{CMD_END, shadow_func[top] ^ 8'($urandom_range(1, 255)), now};
				feed_event(e, 1'b0, none);
			end else begin
				case ($urandom_range(0, 49))
					0: begin
						now = $urandom;
					end
					1: begin
						now += $urandom_range(0, 32'h000F_FFFF);
					end
					default: begin
						now += $urandom_range(0, 9);
					end
				endcase
				if (shadow_depth == 0 || (shadow_depth < STACK_DEPTH &&
						$urandom_range(0, 99) < (shadow_depth < 8 ? 60 : 35))) begin
					e = '{CMD_START, 8'($urandom_range(0, 255)), now};
				end else begin
					e = '{CMD_END, shadow_func[shadow_depth-1], now};
				end
				feed_event(e, 1'b0, none);
			end
		end
		evt_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("** call_stack_exclusive_time_core: PASSED **");
		end else begin
			$display("** call_stack_exclusive_time_core: FAILED **");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/cset_pkg.sv
src/cset_ram.sv
src/cset_alu.sv
src/call_stack_exclusive_time_core.sv
src/cset_checker.sv
bench/call_stack_exclusive_time_core_tb.sv
